FILE: sv/pqt_pkg.sv
package pqt_pkg;

    // Default number of queue slots
    localparam int CAPACITY_DEF = 16;

    // Field widths of one beat
    localparam int FIELD_W  = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 56;

    // Input item kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_POP    = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd3;

    // One queue slot
    typedef struct packed {
        logic [FIELD_W-1:0] time_tag;
        logic [FIELD_W-1:0] prio;
        logic [FIELD_W-1:0] id;
    } entry_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   rem;
        entry_t item;
    } cmd_t;

    // Search token walking down the chain
    typedef struct packed {
        logic               valid;
        logic               scan;
        logic               have;
        logic [FIELD_W-1:0] head_prio;
        entry_t             best;
    } tok_t;

endpackage

FILE: sv/pqt_cell.sv
module pqt_cell #(
    parameter int IDX_W = 4,
    parameter int INDEX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pqt_pkg::cmd_t       cmd,
    input  logic [IDX_W-1:0]    rem_idx,
    input  pqt_pkg::entry_t     left_entry,
    input  logic                left_valid,
    input  logic                left_gt,
    input  pqt_pkg::entry_t     right_entry,
    input  logic                right_valid,
    input  pqt_pkg::tok_t       tok_in,
    input  logic [IDX_W-1:0]    tok_idx_in,
    output pqt_pkg::entry_t     entry,
    output logic                valid,
    output logic                gt,
    output pqt_pkg::tok_t       tok_out,
    output logic [IDX_W-1:0]    tok_idx_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    pqt_pkg::entry_t  entry_reg;
    pqt_pkg::entry_t  entry_next;
    logic             valid_reg;
    logic             valid_next;
    logic             tok_valid_reg;
    pqt_pkg::tok_t    tok_reg;
    pqt_pkg::tok_t    tok_next;
    logic [IDX_W-1:0] tok_idx_reg;
    logic [IDX_W-1:0] tok_idx_next;
    logic             match;
    logic             take;

    // Slot sits behind the new item when empty or of higher priority value
    assign gt = !valid_reg || (entry_reg.prio > cmd.item.prio);

    // Insert shifts right from the insert point, remove shifts left onto the gap
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (cmd.ins)
        begin
            if (left_gt)
            begin
                entry_next = left_entry;
                valid_next = left_valid;
            end
            else if (gt)
            begin
                entry_next = cmd.item;
                valid_next = 1'b1;
            end
        end
        else if (cmd.rem && (MY_IDX >= rem_idx))
        begin
            entry_next = right_entry;
            valid_next = right_valid;
        end
    end

    // Compare own slot against the best carried so far in the leading group
    always_comb
    begin
        match = tok_in.scan && valid_reg &&
                (!tok_in.have || (entry_reg.prio == tok_in.head_prio));
        take  = match && (!tok_in.have || (entry_reg.time_tag < tok_in.best.time_tag));
        tok_next.valid     = 1'b1;
        tok_next.scan      = match;
        tok_next.have      = tok_in.have || match;
        tok_next.head_prio = tok_in.have ? tok_in.head_prio : entry_reg.prio;
        tok_next.best      = take ? entry_reg : tok_in.best;
        tok_idx_next       = take ? MY_IDX : tok_idx_in;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            tok_valid_reg <= tok_in.valid;
        end
    end

    // Hold slot and token payload
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (tok_in.valid)
        begin
            tok_reg     <= tok_next;
            tok_idx_reg <= tok_idx_next;
        end
    end

    // Present the token with its own valid
    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = tok_valid_reg;
    end

    assign entry       = entry_reg;
    assign valid       = valid_reg;
    assign tok_idx_out = tok_idx_reg;

endmodule

FILE: sv/priority_queue_time_tiebreak.sv
// Channel  Direction  Fields (lowest bit up)
// s_*      in         tuser: kind; tdata: entry_id, entry_priority, entry_time
// m_*      out        tuser: status; tdata: removed_id, removed_priority,
//                     removed_time, occupancy, zero pad
//
// Insert and insert on full pass through S_INS, pop on empty through S_POP.
// A pop on a non-empty queue waits in S_SCAN first: a search token walks
// the chain of cells one cell per cycle to find the entry to remove.
// Reset empties the queue at once; slot contents are left as they are.
// A result waiting on m_tready does not block the next input beat, but that
// item does not commit until the output register is free.
module priority_queue_time_tiebreak #(
    parameter int CAPACITY = pqt_pkg::CAPACITY_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pqt_pkg::S_DATA_W-1:0]    s_tdata,  // entry_id, entry_priority, entry_time
    input  logic [0:0]                      s_tuser,  // kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pqt_pkg::M_DATA_W-1:0]    m_tdata,  // removed_id, removed_priority,
                                                      // removed_time, occupancy, pad
    output logic [pqt_pkg::STATUS_W-1:0]    m_tuser   // status
);

    localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PAD_W = pqt_pkg::M_DATA_W - 3 * pqt_pkg::FIELD_W - pqt_pkg::OCC_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_SCAN,
        S_POP
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    pqt_pkg::entry_t               item_reg;
    pqt_pkg::entry_t               item_next;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [pqt_pkg::STATUS_W-1:0]  out_status_reg;
    logic [pqt_pkg::STATUS_W-1:0]  out_status_next;
    pqt_pkg::entry_t               out_entry_reg;
    pqt_pkg::entry_t               out_entry_next;
    logic [pqt_pkg::OCC_W-1:0]     out_occ_reg;
    logic [pqt_pkg::OCC_W-1:0]     out_occ_next;
    logic [CNT_W+pqt_pkg::OCC_W-1:0] occ_ext;

    logic                          s_accept;
    logic                          out_free;
    logic                          emit;
    pqt_pkg::cmd_t                 cmd;
    logic [IDX_W-1:0]              rem_idx;
    pqt_pkg::tok_t                 inject;

    pqt_pkg::entry_t               entry_w   [CAPACITY];
    logic                          valid_w   [CAPACITY];
    logic                          gt_w      [CAPACITY];
    pqt_pkg::tok_t                 tok_w     [CAPACITY];
    logic [IDX_W-1:0]              tok_idx_w [CAPACITY];

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Start a search token at the head on a pop of a non-empty queue
    always_comb
    begin
        inject       = '0;
        inject.valid = s_accept && (s_tuser[0] == pqt_pkg::KIND_POP) && (count_reg != '0);
        inject.scan  = 1'b1;
    end

    // Sequence items and form results
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        count_next      = count_reg;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        emit            = 1'b0;
        cmd             = '0;
        cmd.item        = item_reg;
        rem_idx         = tok_idx_w[CAPACITY-1];
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    item_next = pqt_pkg::entry_t'(s_tdata);
                    if (s_tuser[0] == pqt_pkg::KIND_INSERT)
                        state_next = S_INS;
                    else if (count_reg == '0)
                        state_next = S_POP;
                    else
                        state_next = S_SCAN;
                end
            end
            S_INS:
            begin
                if (out_free)
                begin
                    emit           = 1'b1;
                    out_entry_next = '0;
                    state_next     = S_IDLE;
                    if (count_reg == FULL_CNT)
                        out_status_next = pqt_pkg::ST_DROPPED;
                    else
                    begin
                        out_status_next = pqt_pkg::ST_INSERTED;
                        cmd.ins         = 1'b1;
                        count_next      = count_reg + 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                if (tok_w[CAPACITY-1].valid)
                    state_next = S_POP;
            end
            S_POP:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (count_reg == '0)
                    begin
                        out_status_next = pqt_pkg::ST_EMPTY;
                        out_entry_next  = '0;
                    end
                    else
                    begin
                        out_status_next = pqt_pkg::ST_REMOVED;
                        out_entry_next  = tok_w[CAPACITY-1].best;
                        cmd.rem         = 1'b1;
                        count_next      = count_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Occupancy carries the low bits of the count
    assign occ_ext        = (CNT_W + pqt_pkg::OCC_W)'(count_next);
    assign out_occ_next   = occ_ext[pqt_pkg::OCC_W-1:0];
    assign out_valid_next = emit || (out_valid_reg && !m_tready);

    // Hold state, item and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            item_reg       <= '0;
            out_status_reg <= '0;
            out_entry_reg  <= '0;
            out_occ_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            item_reg      <= item_next;
            if (emit)
            begin
                out_status_reg <= out_status_next;
                out_entry_reg  <= out_entry_next;
                out_occ_reg    <= out_occ_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_occ_reg, out_entry_reg.time_tag,
                       out_entry_reg.prio, out_entry_reg.id};

    // Chain of slot cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        pqt_pkg::entry_t  left_entry;
        logic             left_valid;
        logic             left_gt;
        pqt_pkg::entry_t  right_entry;
        logic             right_valid;
        pqt_pkg::tok_t    tok_in;
        logic [IDX_W-1:0] tok_idx_in;

        if (i == 0)
        begin : g_head
            assign left_entry = '0;
            assign left_valid = 1'b0;
            assign left_gt    = 1'b0;
            assign tok_in     = inject;
            assign tok_idx_in = '0;
        end
        else
        begin : g_body
            assign left_entry = entry_w[i-1];
            assign left_valid = valid_w[i-1];
            assign left_gt    = gt_w[i-1];
            assign tok_in     = tok_w[i-1];
            assign tok_idx_in = tok_idx_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_entry = '0;
            assign right_valid = 1'b0;
        end
        else
        begin : g_inner
            assign right_entry = entry_w[i+1];
            assign right_valid = valid_w[i+1];
        end

        pqt_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .rem_idx     (rem_idx),
            .left_entry  (left_entry),
            .left_valid  (left_valid),
            .left_gt     (left_gt),
            .right_entry (right_entry),
            .right_valid (right_valid),
            .tok_in      (tok_in),
            .tok_idx_in  (tok_idx_in),
            .entry       (entry_w[i]),
            .valid       (valid_w[i]),
            .gt          (gt_w[i]),
            .tok_out     (tok_w[i]),
            .tok_idx_out (tok_idx_w[i])
        );
    end

endmodule
